// ===== rtl/qpd_pkg.sv =====
// Package: shared types, constants and nibble lookup for the quoted-printable decoder.
`timescale 1ns / 1ps

package qpd_pkg;

    localparam int QPD_QUEUE_DEPTH = 4;

    localparam logic [7:0] QP_EQ    = 8'h3D;
    localparam logic [7:0] QP_ZERO  = 8'h30;
    localparam int         QP_SPAN  = 23;
    localparam int         QP_SHIFT = 4;
    localparam int         MAX_OUT  = 3;

    localparam logic [3:0] NIB_TAB [0:QP_SPAN-1] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9,
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
    };

    typedef struct packed {
        logic                    last;
        logic [1:0]              cnt;
        logic [MAX_OUT-1:0][7:0] data;
    } job_t;

    function automatic logic is_digit(input logic [7:0] b);
        logic [7:0] off;
        begin
            off = b - QP_ZERO;
            return (b >= QP_ZERO) && (off < 8'(QP_SPAN));
        end
    endfunction

    function automatic logic [3:0] nibble(input logic [7:0] b);
        logic [7:0] off;
        begin
            off = b - QP_ZERO;
            if (off < 8'(QP_SPAN))
            begin
                return NIB_TAB[off[4:0]];
            end
            return 4'd0;
        end
    endfunction

endpackage

// ===== rtl/qpd_front.sv =====
// Front end: accept input words, track escape state, build output jobs.
`timescale 1ns / 1ps

module qpd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] in_byte
    input  logic          s_tlast,   // in_last
    input  logic          q_full,
    output logic          q_push,
    output qpd_pkg::job_t q_job
);
    import qpd_pkg::*;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_EQ    = 2'd1;
    localparam logic [1:0] PH_FIRST = 2'd2;

    logic [1:0] phase_reg, phase_next;
    logic [7:0] first_reg, first_next;
    logic       accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        phase_next = phase_reg;
        first_next = first_reg;
        q_job      = '0;
        q_job.last = s_tlast;
        unique case (phase_reg)
            PH_EQ:
            begin
                if (s_tlast)
                begin
                    q_job.cnt     = 2'd2;
                    q_job.data[0] = QP_EQ;
                    q_job.data[1] = s_tdata;
                end
                else
                begin
                    first_next = s_tdata;
                    phase_next = PH_FIRST;
                end
            end
            PH_FIRST:
            begin
                if (is_digit(first_reg) && is_digit(s_tdata))
                begin
                    q_job.cnt     = 2'd1;
                    q_job.data[0] = {nibble(first_reg), nibble(s_tdata)};
                end
                else
                begin
                    q_job.cnt     = 2'd3;
                    q_job.data[0] = QP_EQ;
                    q_job.data[1] = first_reg;
                    q_job.data[2] = s_tdata;
                end
                phase_next = PH_IDLE;
                first_next = 8'd0;
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (s_tdata == QP_EQ && !s_tlast)
                begin
                    phase_next = PH_EQ;
                end
                else
                begin
                    q_job.cnt     = 2'd1;
                    q_job.data[0] = s_tdata;
                end
            end
        endcase
        if (s_tlast)
        begin
            phase_next = PH_IDLE;
            first_next = 8'd0;
        end
    end

    assign q_push = accept && (q_job.cnt != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            first_reg <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            first_reg <= first_next;
        end
    end

endmodule

// ===== rtl/qpd_queue.sv =====
// Job queue between front end and back end.
`timescale 1ns / 1ps

module qpd_queue #(
    parameter int DEPTH = qpd_pkg::QPD_QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  qpd_pkg::job_t wjob,
    input  logic          pop,
    output qpd_pkg::job_t rjob,
    output logic          full,
    output logic          empty
);
    import qpd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem_reg [0:DEPTH-1];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign rjob  = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wjob;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/qpd_back.sv =====
// Back end: serialize queued jobs into output words through an output register.
`timescale 1ns / 1ps

module qpd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  qpd_pkg::job_t q_job,
    input  logic          q_empty,
    output logic          q_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,   // [7:0] out_byte
    output logic [0:0]    m_tuser,   // [0] run_last
    output logic          m_tlast    // stream_end
);
    import qpd_pkg::*;

    logic       valid_reg, valid_next;
    logic [7:0] data_reg;
    logic       run_last_reg;
    logic       end_reg;
    logic [1:0] idx_reg, idx_next;
    logic       load;
    logic       job_done;

    assign load     = !q_empty && (!valid_reg || m_tready);
    assign job_done = (idx_reg == (q_job.cnt - 2'd1));
    assign q_pop    = load && job_done;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = job_done ? 2'd0 : idx_reg + 2'd1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg     <= q_job.data[idx_reg];
            run_last_reg <= job_done;
            end_reg      <= job_done && q_job.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    assign m_tvalid   = valid_reg;
    assign m_tdata    = data_reg;
    assign m_tuser[0] = run_last_reg;
    assign m_tlast    = end_reg;

    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && end_reg |-> run_last_reg)
        else $error("stream end without run end");

    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> (idx_reg < q_job.cnt))
        else $error("job index past job length");

    a_idx_clear_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_empty |-> (idx_reg == 2'd0))
        else $error("job index left over with empty queue");

endmodule

// ===== rtl/quoted_printable_decoder_core.sv =====
// Top level: quoted-printable decoder with decoupled classify and emit stages.
//
// Usage:
//   Input stream (s_*): one raw encoded byte per word in s_tdata[7:0]; s_tlast
//   marks the final byte of a stream. A word is taken when s_tvalid and
//   s_tready are both high.
//   Output stream (m_*): one decoded or literal byte per word in m_tdata[7:0];
//   m_tuser[0] marks the last byte caused by one input word, m_tlast marks
//   the final byte of the stream.
//   Path: a byte that produces output goes through the job queue and then the
//   output register to m_*, when the queue is empty and the receiver is ready.
//   Throughput: one input word per cycle until the queue is full; the output
//   side emits one byte per cycle while m_tready is high, so a failed escape
//   (three bytes out) holds the emitter for all three bytes. The job queue of
//   QUEUE_DEPTH entries absorbs such bursts; s_tready drops only when it is full.
//   Reset: clears escape state, queue and output valid flag; no outputs valid.
//   Stall: while m_tready is low the output word holds and the queue fills;
//   input keeps flowing until the queue is full.
`timescale 1ns / 1ps

module quoted_printable_decoder_core #(
    parameter int QUEUE_DEPTH = qpd_pkg::QPD_QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [0:0] m_tuser,   // [0] run_last
    output logic       m_tlast    // stream_end
);
    import qpd_pkg::*;

    job_t push_job;
    job_t head_job;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;

    qpd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    qpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wjob  (push_job),
        .pop   (q_pop),
        .rjob  (head_job),
        .full  (q_full),
        .empty (q_empty)
    );

    qpd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_job    (head_job),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== test/tb.sv =====
// Testbench: quoted-printable decoder core run on directed and random streams against a predictor.
`timescale 1ns / 1ps

module tb;

    import qpd_pkg::QP_EQ;
    import qpd_pkg::QP_ZERO;

    localparam logic [7:0] HEX_TOP    = 8'h46;
    localparam logic [7:0] HEX_NINE   = 8'h39;
    localparam logic [7:0] HEX_A      = 8'h41;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_G     = 8'h47;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_AT    = 8'h40;
    localparam int         TOTAL_WORDS  = 160;
    localparam int         DRAIN_CYCLES = 12;

    typedef enum logic [1:0] {PH_IDLE, PH_EQ_SEEN, PH_FIRST_SEEN, PH_SPARE} esc_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } enc_word_t;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       stream_end;
    } dec_word_t;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'h00;
    logic       s_tlast   = 1'b0;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;
    logic [0:0] m_tuser;
    logic       m_tlast;

    quoted_printable_decoder_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    enc_word_t  pending_words[$];
    dec_word_t  expected_bytes[$];

    esc_phase_t esc_phase  = PH_IDLE;
    logic [7:0] held_digit = 8'h00;

    logic       in_taken   = 1'b0;
    int         gap_left   = 0;
    int         burst_left = 1;
    int         rx_cycle   = 0;
    int         rx_mode    = 0;
    int         fail_count = 0;
    int         words_in   = 0;
    int         bytes_out  = 0;
    int         streams_done    = 0;
    int         escapes_decoded = 0;
    int         escapes_literal = 0;
    enc_word_t  next_word;
    dec_word_t  want;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic is_hex(input logic [7:0] b);
        return (b >= QP_ZERO) && (b <= HEX_TOP);
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] b);
        if (b <= HEX_NINE)
        begin
            return b[3:0];
        end
        if (b >= HEX_A)
        begin
            return b[3:0] + 4'd9;
        end
        return 4'd0;
    endfunction

    task automatic decode_word(input enc_word_t w);
        dec_word_t outs[3];
        int        n;
        n = 0;
        case (esc_phase)
            PH_EQ_SEEN:
            begin
                if (w.last)
                begin
                    outs[n] = {QP_EQ, 2'b00};
                    n++;
                    outs[n] = {w.data, 2'b00};
                    n++;
                end
                else
                begin
                    held_digit = w.data;
                    esc_phase  = PH_FIRST_SEEN;
                end
            end
            PH_FIRST_SEEN:
            begin
                if (is_hex(held_digit) && is_hex(w.data))
                begin
                    outs[n] = {hex_value(held_digit), hex_value(w.data), 2'b00};
                    n++;
                    escapes_decoded++;
                end
                else
                begin
                    outs[n] = {QP_EQ, 2'b00};
                    n++;
                    outs[n] = {held_digit, 2'b00};
                    n++;
                    outs[n] = {w.data, 2'b00};
                    n++;
                    escapes_literal++;
                end
                esc_phase  = PH_IDLE;
                held_digit = 8'h00;
            end
            default:
            begin
                esc_phase = PH_IDLE;
                if (w.data == QP_EQ && !w.last)
                begin
                    esc_phase = PH_EQ_SEEN;
                end
                else
                begin
                    outs[n] = {w.data, 2'b00};
                    n++;
                end
            end
        endcase
        if (n > 0)
        begin
            outs[n-1].run_last   = 1'b1;
            outs[n-1].stream_end = w.last;
        end
        if (w.last)
        begin
            esc_phase  = PH_IDLE;
            held_digit = 8'h00;
        end
        for (int k = 0; k < n; k++)
        begin
            expected_bytes.push_back(outs[k]);
        end
    endtask

    task automatic add_word(input logic [7:0] data, input logic last);
        enc_word_t w;
        w.data = data;
        w.last = last;
        pending_words.push_back(w);
    endtask

    task automatic add_escape(input logic [7:0] a, input logic [7:0] b, input logic last);
        add_word(QP_EQ, 1'b0);
        add_word(a, 1'b0);
        add_word(b, last);
    endtask

    function automatic logic [7:0] rand_hex();
        return QP_ZERO + 8'($urandom_range(0, 22));
    endfunction

    task automatic add_random_stream();
        int         segs;
        int         kind;
        logic [7:0] b;
        segs = $urandom_range(1, 10);
        for (int s = 0; s < segs; s++)
        begin
            kind = $urandom_range(0, 9);
            case (kind) inside
                [0:3]:
                begin
                    b = 8'($urandom_range(0, 255));
                    if (b == QP_EQ)
                    begin
                        b = HEX_A;
                    end
                    add_word(b, 1'b0);
                end
                [4:6]: add_escape(rand_hex(), rand_hex(), 1'b0);
                7: add_escape(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
                8: add_escape(CHAR_CR, CHAR_LF, 1'b0);
                default: add_word(8'($urandom_range(0, 255)), 1'b0);
            endcase
        end
        case ($urandom_range(0, 7))
            0: add_word(QP_EQ, 1'b0);
            1:
            begin
                add_word(QP_EQ, 1'b0);
                add_word(rand_hex(), 1'b0);
            end
            default: ;
        endcase
        if (pending_words[$].data == QP_EQ && $urandom_range(0, 1) == 0)
        begin
            add_word(8'($urandom_range(0, 255)), 1'b0);
        end
        pending_words[$].last = 1'b1;
    endtask

    // accept input words, predict, and check output words
    always @(posedge clk)
    begin
        in_taken <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            decode_word({s_tdata, s_tlast});
            words_in++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            bytes_out++;
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected output word data=%02h run_last=%0b stream_end=%0b",
                         $time, m_tdata, m_tuser[0], m_tlast);
                fail_count++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (m_tdata !== want.data)
                begin
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, want.data, m_tdata);
                    fail_count++;
                end
                if (m_tuser[0] !== want.run_last)
                begin
                    $display("%0t: run_last expected %0b actual %0b",
                             $time, want.run_last, m_tuser[0]);
                    fail_count++;
                end
                if (m_tlast !== want.stream_end)
                begin
                    $display("%0t: stream_end expected %0b actual %0b",
                             $time, want.stream_end, m_tlast);
                    fail_count++;
                end
                if (want.stream_end)
                begin
                    streams_done++;
                end
            end
        end
    end

    // hold the word until taken, then advance in bursts with gaps
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (gap_left > 0)
            begin
                s_tvalid <= 1'b0;
                gap_left--;
            end
            else if (pending_words.size() > 0)
            begin
                next_word = pending_words.pop_front();
                s_tdata  <= next_word.data;
                s_tlast  <= next_word.last;
                s_tvalid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        rx_cycle++;
        if (rx_cycle % 48 == 0)
        begin
            rx_mode = $urandom_range(0, 3);
        end
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            2: m_tready <= (rx_cycle % 5 == 0);
            default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    initial
    begin
        add_word(8'h00, 1'b0);
        add_word(8'hFF, 1'b0);
        add_escape(HEX_TOP, HEX_TOP, 1'b0);
        add_escape(CHAR_COLON, CHAR_AT, 1'b0);
        add_escape(HEX_NINE - 8'd6, CHAR_LOW_A, 1'b0);
        add_escape(CHAR_CR, CHAR_LF, 1'b0);
        add_escape(CHAR_SLASH, QP_ZERO, 1'b0);
        add_escape(HEX_TOP, CHAR_G, 1'b1);
        add_word(QP_EQ, 1'b1);
        add_word(QP_EQ, 1'b0);
        add_word(HEX_A, 1'b1);
        add_word(8'h80, 1'b1);
        while (pending_words.size() < TOTAL_WORDS)
        begin
            add_random_stream();
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_words.size() > 0 || s_tvalid || expected_bytes.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Streamed %0d encoded words in %0d streams, checked %0d decoded words.",
                 words_in, streams_done, bytes_out);
        $display("Escapes: %0d decoded to a byte, %0d passed through literally.",
                 escapes_decoded, escapes_literal);
        if (fail_count == 0 && expected_bytes.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
